/* sv/timed_event_slot_table_top_defines.svh */
// Assertion macros shared by the slot table RTL.
`ifndef TIMED_EVENT_SLOT_TABLE_TOP_DEFINES_SVH
`define TIMED_EVENT_SLOT_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TETS_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) \
    else $error("assertion failed");
`define TETS_ASSERT_NEVER(lbl, clk_s, rst_s, cond) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) \
    else $error("forbidden condition seen");
`else
`define TETS_ASSERT(lbl, clk_s, rst_s, prop)
`define TETS_ASSERT_NEVER(lbl, clk_s, rst_s, cond)
`endif
`endif

/* sv/tets_pkg.sv */
`default_nettype none
package tets_pkg;

  localparam int ID_W           = 16;
  localparam int TIME_W         = 31;
  localparam int FUNC_W         = 2;
  localparam int SLOT_COUNT_DEF = 16;

  localparam logic [FUNC_W-1:0] FUNC_ADD     = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SERVICE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              scan;
    logic [ID_W-1:0]   event_id;
    logic [TIME_W-1:0] time_value;
  } cmd_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
  } head_t;

  typedef struct packed {
    logic            strobe;
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            status;
    logic            halted;
    logic            last;
  } res_t;

  function automatic res_t mk_res(input logic fired, input logic [ID_W-1:0] fired_id,
                                  input logic status, input logic halted,
                                  input logic last);
    res_t r;
    r.strobe   = 1'b1;
    r.fired    = fired;
    r.fired_id = fired_id;
    r.status   = status;
    r.halted   = halted;
    r.last     = last;
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/tets_ram.sv */
`default_nettype none
module tets_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/tets_front.sv */
`default_nettype none
`include "timed_event_slot_table_top_defines.svh"
module tets_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tets_pkg::FUNC_W-1:0]  func,
  input  logic [tets_pkg::ID_W-1:0]    event_id,
  input  logic [tets_pkg::TIME_W-1:0]  time_value,
  output logic                         busy,
  input  logic                         pop,
  output tets_pkg::head_t              head
);
  import tets_pkg::*;

  cmd_t       q [2];
  cmd_t       new_cmd;
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;

  assign busy = (cnt == 2'd2);
  assign push = start && !busy;

  // Clear-all needs no pass over the slots; everything else does.
  always_comb begin
    new_cmd.func       = func;
    new_cmd.scan       = (func != FUNC_CLEAR);
    new_cmd.event_id   = event_id;
    new_cmd.time_value = time_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  assign head.vld = (cnt != 2'd0);
  assign head.cmd = q[rd_ptr];

  `TETS_ASSERT_NEVER(a_cnt_range, clk, rst, cnt == 2'd3)
  `TETS_ASSERT(a_pop_nonempty, clk, rst, pop |-> cnt != 2'd0)

endmodule
`default_nettype wire

/* sv/tets_back.sv */
`default_nettype none
`include "timed_event_slot_table_top_defines.svh"
module tets_back #(
  parameter int SLOT_COUNT = tets_pkg::SLOT_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  tets_pkg::head_t head,
  output logic            pop,
  output tets_pkg::res_t  res
);
  import tets_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int ENT_W = ID_W + TIME_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]            state;
  logic [IDX_W-1:0]      idx;
  cmd_t                  cmd;
  logic                  have_free;
  logic [IDX_W-1:0]      free_idx;
  logic                  pend_vld;
  logic [ID_W-1:0]       pend_id;
  logic                  halt_flag;
  logic [SLOT_COUNT-1:0] valid;

  logic                  we;
  logic [IDX_W-1:0]      waddr;
  logic [ENT_W-1:0]      wdata;
  logic [IDX_W-1:0]      raddr;
  logic [ENT_W-1:0]      rdata;

  logic                  is_last;
  logic [ID_W-1:0]       e_id;
  logic [TIME_W-1:0]     e_dl;
  logic                  id_hit;
  logic                  free_now;
  logic                  expired;
  logic                  room;

  tets_ram #(.WIDTH(ENT_W), .DEPTH(SLOT_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read data belongs to slot idx; a slot without its valid bit reads as empty.
  assign is_last  = (idx == IDX_W'(SLOT_COUNT - 1));
  assign e_id     = valid[idx] ? rdata[ENT_W-1:TIME_W] : '0;
  assign e_dl     = valid[idx] ? rdata[TIME_W-1:0] : '0;
  assign id_hit   = (e_id == cmd.event_id);
  assign free_now = (e_dl == '0);
  assign expired  = !free_now && (cmd.time_value >= e_dl);
  assign room     = have_free || free_now;
  assign pop      = (state == S_IDLE) && head.vld;

  // The next slot is fetched while the current one is examined.
  assign raddr = ((state == S_IDLE) || is_last) ? '0 : idx + 1'b1;

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = {cmd.event_id, cmd.time_value};
    if (state == S_SCAN && cmd.func == FUNC_ADD) begin
      if (id_hit) begin
        we = 1'b1;
      end else if (is_last && room) begin
        we    = 1'b1;
        waddr = have_free ? free_idx : idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      halt_flag <= 1'b0;
      have_free <= 1'b0;
      pend_vld  <= 1'b0;
      res       <= '0;
    end else begin
      res <= '0;
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (head.vld) begin
            cmd       <= head.cmd;
            idx       <= '0;
            have_free <= 1'b0;
            pend_vld  <= 1'b0;
            if (head.cmd.scan) begin
              state <= S_SCAN;
            end else begin
              valid <= '0;
              res   <= mk_res(1'b0, '0, 1'b0, halt_flag, 1'b1);
            end
          end
        end
        S_SCAN: begin
          idx <= idx + 1'b1;
          unique case (cmd.func)
            FUNC_ADD: begin
              if (id_hit || is_last) begin
                state <= S_IDLE;
                if (!id_hit && !room) begin
                  halt_flag <= 1'b1;
                  res       <= mk_res(1'b0, '0, 1'b1, 1'b1, 1'b1);
                end else begin
                  res <= mk_res(1'b0, '0, 1'b0, halt_flag, 1'b1);
                end
              end else if (free_now && !have_free) begin
                have_free <= 1'b1;
                free_idx  <= idx;
              end
            end
            FUNC_CANCEL: begin
              if (id_hit) begin
                valid[idx] <= 1'b0;
              end
              if (id_hit || is_last) begin
                state <= S_IDLE;
                res   <= mk_res(1'b0, '0, 1'b0, halt_flag, 1'b1);
              end
            end
            FUNC_SERVICE: begin
              // One hit is held back so that the final beat can carry last.
              if (expired) begin
                valid[idx] <= 1'b0;
                pend_id    <= e_id;
                pend_vld   <= 1'b1;
                if (pend_vld) begin
                  res <= mk_res(1'b1, pend_id, 1'b0, halt_flag, 1'b0);
                end
                if (is_last) begin
                  state <= S_FLUSH;
                end
              end else if (is_last) begin
                state <= S_IDLE;
                if (pend_vld) begin
                  res <= mk_res(1'b1, pend_id, 1'b0, halt_flag, 1'b1);
                end else begin
                  res <= mk_res(1'b0, '0, 1'b0, halt_flag, 1'b1);
                end
              end
            end
            default: begin
              state <= S_IDLE;
              res   <= mk_res(1'b0, '0, 1'b0, halt_flag, 1'b1);
            end
          endcase
        end
        S_FLUSH: begin
          state    <= S_IDLE;
          pend_vld <= 1'b0;
          res      <= mk_res(1'b1, pend_id, 1'b0, halt_flag, 1'b1);
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TETS_ASSERT(a_full_beat, clk, rst, res.strobe && res.status |-> res.halted && res.last && !res.fired)
  `TETS_ASSERT(a_halt_sticky, clk, rst, halt_flag |=> halt_flag)
  `TETS_ASSERT(a_pop_starts, clk, rst, pop |=> state == S_SCAN || res.strobe)
  `TETS_ASSERT_NEVER(a_pop_busy, clk, rst, pop && state != S_IDLE)

endmodule
`default_nettype wire

/* sv/timed_event_slot_table_top.sv */
// Table of SLOT_COUNT one-shot timed events. A command is taken when start is
// high and busy is low; a two-deep command queue in front lets a new command
// in while the slot engine is still working. The engine walks the slots one
// per cycle through a single-port-read slot RAM, so add, cancel and service
// make at most one pass over the slots (a service hit in the final slot
// adds a flush state) and clear-all makes none. Every command yields one or
// more result beats, each shown for exactly one cycle with strobe high; the
// receiver cannot stall them, so it must take every strobed beat. last marks
// the final beat of a command; halted in a beat is sticky until reset.
`default_nettype none
module timed_event_slot_table_top #(
  parameter int SLOT_COUNT = tets_pkg::SLOT_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [tets_pkg::FUNC_W-1:0]  func,
  input  logic [tets_pkg::ID_W-1:0]    event_id,
  input  logic [tets_pkg::TIME_W-1:0]  time_value,
  output logic                         strobe,
  output logic                         fired,
  output logic [tets_pkg::ID_W-1:0]    fired_id,
  output logic                         status,
  output logic                         halted,
  output logic                         last
);
  import tets_pkg::*;

  head_t head;
  logic  pop;
  res_t  res;

  tets_front u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .event_id   (event_id),
    .time_value (time_value),
    .busy       (busy),
    .pop        (pop),
    .head       (head)
  );

  tets_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .res  (res)
  );

  assign strobe   = res.strobe;
  assign fired    = res.fired;
  assign fired_id = res.fired_id;
  assign status   = res.status;
  assign halted   = res.halted;
  assign last     = res.last;

endmodule
`default_nettype wire

/* dv/tb_timed_event_slot_table_top.sv */
`timescale 1ns / 1ps
module tb_timed_event_slot_table_top;
  import tets_pkg::*;

  localparam int SLOTS         = SLOT_COUNT_DEF;
  localparam int SETTLE_CYCLES = 3 * SLOTS + 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int POOL_SIZE     = 24;
  localparam int PHASE_ITEMS   = 113;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   event_id;
    logic [TIME_W-1:0] time_value;
    int unsigned       idle_pct;
    bit                drain;
  } timer_cmd_t;

  typedef struct packed {
    logic            fired;
    logic [ID_W-1:0] fired_id;
    logic            status;
    logic            halted;
    logic            last;
  } timer_beat_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [FUNC_W-1:0] func = FUNC_ADD;
  logic [ID_W-1:0]   event_id = '0;
  logic [TIME_W-1:0] time_value = '0;
  logic              strobe;
  logic              fired;
  logic [ID_W-1:0]   fired_id;
  logic              status;
  logic              halted;
  logic              last;

  timer_cmd_t  cmd_queue[$];
  timer_beat_t expected_beats[$];

  // Shadow copy of the event table.
  logic [ID_W-1:0]   shadow_id[SLOTS];
  logic [TIME_W-1:0] shadow_deadline[SLOTS];
  logic              shadow_halt;

  int          mismatches  = 0;
  int          cycle_count = 0;
  timer_cmd_t  next_cmd;
  timer_beat_t seen_beat;
  timer_beat_t want_beat;

  timed_event_slot_table_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .func       (func),
    .event_id   (event_id),
    .time_value (time_value),
    .strobe     (strobe),
    .fired      (fired),
    .fired_id   (fired_id),
    .status     (status),
    .halted     (halted),
    .last       (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void predict_slot_table(input logic [FUNC_W-1:0] op,
                                             input logic [ID_W-1:0] id,
                                             input logic [TIME_W-1:0] t);
    int              free_idx;
    bit              hit;
    logic            full;
    logic [ID_W-1:0] expired[$];
    free_idx = -1;
    hit      = 1'b0;
    full     = 1'b0;
    case (op)
      FUNC_ADD: begin
        // An id match wins even when that slot is free.
        for (int i = 0; i < SLOTS && !hit; i++) begin
          if (shadow_id[i] == id) begin
            shadow_deadline[i] = t;
            hit = 1'b1;
          end else if (free_idx < 0 && shadow_deadline[i] == '0) begin
            free_idx = i;
          end
        end
        if (!hit) begin
          if (free_idx >= 0) begin
            shadow_id[free_idx]       = id;
            shadow_deadline[free_idx] = t;
          end else begin
            shadow_halt = 1'b1;
            full        = 1'b1;
          end
        end
      end
      FUNC_CANCEL: begin
        for (int i = 0; i < SLOTS && !hit; i++) begin
          if (shadow_id[i] == id) begin
            shadow_id[i]       = '0;
            shadow_deadline[i] = '0;
            hit = 1'b1;
          end
        end
      end
      FUNC_SERVICE: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (shadow_deadline[i] != '0 && t >= shadow_deadline[i]) begin
            expired.push_back(shadow_id[i]);
            shadow_id[i]       = '0;
            shadow_deadline[i] = '0;
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          shadow_id[i]       = '0;
          shadow_deadline[i] = '0;
        end
      end
    endcase
    if (expired.size() == 0) begin
      expected_beats.push_back('{1'b0, '0, full, shadow_halt, 1'b1});
    end else begin
      for (int k = 0; k < expired.size(); k++) begin
        expected_beats.push_back('{1'b1, expired[k], 1'b0, shadow_halt,
                                   k == expired.size() - 1});
      end
    end
  endfunction

  function automatic void note_mismatch(input string what, input timer_beat_t want,
                                        input timer_beat_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display({"mismatch (%s): expected fired=%0b id=%h status=%0b halted=%0b last=%0b,",
                " got fired=%0b id=%h status=%0b halted=%0b last=%0b"},
               what, want.fired, want.fired_id, want.status, want.halted, want.last,
               got.fired, got.fired_id, got.status, got.halted, got.last);
    end
  endfunction

  function automatic void queue_cmd(input logic [FUNC_W-1:0] op, input logic [ID_W-1:0] id,
                                    input logic [TIME_W-1:0] t, input int unsigned idle,
                                    input bit drain);
    timer_cmd_t c;
    c.func       = op;
    c.event_id   = id;
    c.time_value = t;
    c.idle_pct   = idle;
    c.drain      = drain;
    cmd_queue.push_back(c);
  endfunction

  // Driver: a command beat is taken when start is high and busy is low.
  always @(posedge clk) begin
    if (rst) begin
      start      <= 1'b0;
      func       <= FUNC_ADD;
      event_id   <= '0;
      time_value <= '0;
    end else begin
      if (start && !busy) begin
        predict_slot_table(func, event_id, time_value);
      end
      if (!start || !busy) begin
        if (cmd_queue.size() != 0 && !(cmd_queue[0].drain && expected_beats.size() != 0)
            && $urandom_range(99) >= cmd_queue[0].idle_pct) begin
          next_cmd = cmd_queue.pop_front();
          start      <= 1'b1;
          func       <= next_cmd.func;
          event_id   <= next_cmd.event_id;
          time_value <= next_cmd.time_value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed beat must match the oldest expected beat.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      seen_beat = '{fired, fired_id, status, halted, last};
      if (expected_beats.size() == 0) begin
        note_mismatch("beat with nothing expected", seen_beat, seen_beat);
      end else begin
        want_beat = expected_beats.pop_front();
        if (seen_beat.fired !== want_beat.fired || seen_beat.fired_id !== want_beat.fired_id
            || seen_beat.status !== want_beat.status || seen_beat.halted !== want_beat.halted
            || seen_beat.last !== want_beat.last) begin
          note_mismatch("result beat", want_beat, seen_beat);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timed_event_slot_table_top test failed");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0]   id_pool[POOL_SIZE];
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] t;
    int unsigned       roll;
    int unsigned       phase_idle[4];
    bit                drain;

    for (int i = 0; i < SLOTS; i++) begin
      shadow_id[i]       = '0;
      shadow_deadline[i] = '0;
    end
    shadow_halt = 1'b0;

    // Directed part: empty service, id zero, extremes, zero deadline, cancel,
    // table full, a service that fires every slot, and clear-all.
    queue_cmd(FUNC_SERVICE, 16'h0000, '0, 0, 1'b0);
    queue_cmd(FUNC_ADD, 16'h0000, 31'd5, 0, 1'b0);
    queue_cmd(FUNC_ADD, 16'hFFFF, TIME_MAX, 0, 1'b0);
    queue_cmd(FUNC_ADD, 16'h1234, '0, 0, 1'b0);
    queue_cmd(FUNC_ADD, 16'h1234, 31'd7, 0, 1'b0);
    queue_cmd(FUNC_CANCEL, 16'hFFFF, '0, 0, 1'b0);
    queue_cmd(FUNC_CANCEL, 16'h5555, TIME_MAX, 0, 1'b0);
    for (int k = 0; k < 15; k++) begin
      queue_cmd(FUNC_ADD, 16'hA000 + k[15:0],
                (k % 2 == 0) ? TIME_MAX - TIME_W'(k) : 31'd100 + TIME_W'(k), 0, 1'b0);
    end
    queue_cmd(FUNC_SERVICE, 16'hFFFF, TIME_MAX, 0, 1'b0);
    queue_cmd(FUNC_ADD, 16'h0BEE, 31'd3, 0, 1'b0);
    queue_cmd(FUNC_CLEAR, 16'hFFFF, TIME_MAX, 0, 1'b0);
    queue_cmd(FUNC_SERVICE, 16'h0000, TIME_MAX, 0, 1'b0);

    // Random part: a small id pool keeps matches and a full table common.
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = ID_W'($urandom);
    now = TIME_W'($urandom_range(1000, 1));
    phase_idle = '{0, 86, 0, 37};
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        roll  = $urandom_range(99);
        drain = (k == 0) || ($urandom_range(99) < 2);
        id    = ($urandom_range(9) == 0) ? ID_W'($urandom)
                                         : id_pool[$urandom_range(POOL_SIZE - 1)];
        if (roll < 50) begin
          case ($urandom_range(19))
            0:       t = '0;
            1:       t = TIME_W'($urandom);
            default: t = now + TIME_W'($urandom_range(60, 1));
          endcase
          queue_cmd(FUNC_ADD, id, t, phase_idle[p], drain);
        end else if (roll < 62) begin
          queue_cmd(FUNC_CANCEL, id, TIME_W'($urandom), phase_idle[p], drain);
        end else if (roll < 96) begin
          now = now + TIME_W'($urandom_range(25));
          case ($urandom_range(39))
            0:       t = '0;
            1:       t = TIME_MAX;
            2:       t = TIME_W'($urandom);
            default: t = now;
          endcase
          queue_cmd(FUNC_SERVICE, id, t, phase_idle[p], drain);
        end else begin
          queue_cmd(FUNC_CLEAR, id, TIME_W'($urandom), phase_idle[p], drain);
        end
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || start) @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("timed_event_slot_table_top test passed");
    end else begin
      $display("timed_event_slot_table_top test failed");
    end
    $finish;
  end

endmodule
